@@ rtl/core/checkerboard_floor_ray_hit_assert.svh @@
// ----------------------------------------------------------------------------
// Checkerboard floor ray hit: assertion macros
// Concurrent check wrappers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef CHECKERBOARD_FLOOR_RAY_HIT_ASSERT_SVH
`define CHECKERBOARD_FLOOR_RAY_HIT_ASSERT_SVH

`ifndef SYNTHESIS
// Property holds in the same cycle as its trigger
`define CFRH_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("cfrh assertion failed");
// Property holds in the cycle after its trigger
`define CFRH_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) pre |=> post) \
      else $error("cfrh next-cycle assertion failed");
`else
`define CFRH_ASSERT(lbl, clk, rst, prop)
`define CFRH_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif

`endif

@@ rtl/core/cfrh_pkg.sv @@
// ----------------------------------------------------------------------------
// Checkerboard floor ray hit: package
// Shared widths, register indexes, configuration struct and helpers.
// ----------------------------------------------------------------------------
package cfrh_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int CRD_W           = 32;
   localparam int COLOR_W         = 24;
   localparam int LEN_W           = 31;
   localparam int CNT_W           = 16;
   localparam int SPAN_W          = CNT_W + LEN_W;
   localparam int CSR_ADDR_W      = 5;
   localparam int CSR_DATA_W      = 32;
   localparam int REG_IDX_W       = 3;

   // Register indexes (byte address / 4)
   localparam logic [REG_IDX_W-1:0] REG_MAIN_COLOR   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_ODD_COLOR    = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_FLOOR_ORIGIN = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_TILE_LENGTH  = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_TILE_COUNT   = 3'd4;

   // Reset values
   localparam logic [COLOR_W-1:0] MAIN_COLOR_RST   = 24'hFFFFFF;
   localparam logic [COLOR_W-1:0] ODD_COLOR_RST    = 24'h000000;
   localparam logic [CRD_W-1:0]   FLOOR_ORIGIN_RST = 32'hFE0C0000;
   localparam logic [LEN_W-1:0]   TILE_LENGTH_RST  = 31'h00140000;
   localparam logic [CNT_W-1:0]   TILE_COUNT_RST   = 16'd50;

   // Distance reported on a miss: -1.0
   localparam logic [CRD_W-1:0]   MISS_DISTANCE    = 32'hFFFF0000;

   typedef struct packed {
      logic [COLOR_W-1:0] main_color;
      logic [COLOR_W-1:0] odd_color;
      logic [CRD_W-1:0]   floor_origin;
      logic [LEN_W-1:0]   tile_length;
      logic [CNT_W-1:0]   tile_count;
   } cfg_type;

   // Read the low cw bits as two's complement
   function automatic logic [CRD_W-1:0] sext_crd(input logic [CRD_W-1:0] v, input int cw);
      logic [CRD_W-1:0] r;
      r = v;
      for (int i = 0; i < CRD_W; i++) begin
         if (i >= cw) begin
            r[i] = v[cw-1];
         end
      end
      return r;
   endfunction

   // Magnitude of a signed coordinate, as unsigned
   function automatic logic [CRD_W-1:0] mag_crd(input logic [CRD_W-1:0] v);
      return v[CRD_W-1] ? (~v + 1'b1) : v;
   endfunction

endpackage

@@ rtl/core/checkerboard_floor_ray_hit.sv @@
// ----------------------------------------------------------------------------
// Checkerboard floor ray hit
// Pipeline: two input stages, 63 divider stages for t and the hit point,
// three stages for point and bounds, 17 divider stages for tile index, output.
// Throughput: one ray per cycle while the skid stage is empty; the divider
// pipelines set the depth.
// Reset: synchronous; clears valid bits and loads register defaults.
// ----------------------------------------------------------------------------
`include "checkerboard_floor_ray_hit_assert.svh"

module checkerboard_floor_ray_hit #(
   parameter int COORD_WIDTH = cfrh_pkg::COORD_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // start_x, start_y, start_z, dir_x, dir_y, dir_z (32 bits each, from bit 0)
   input  logic [191:0]                        req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // distance [31:0], hit_color [55:32]
   output logic [55:0]                         rsp_tdata,
   // hit
   output logic                                rsp_tuser,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cfrh_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [cfrh_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [cfrh_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int CW = (COORD_WIDTH < 16) ? 16 : ((COORD_WIDTH > 32) ? 32 : COORD_WIDTH);
   localparam logic signed [63:0] TMAX = (64'sd1 <<< (CW - 1)) - 64'sd1;
   localparam logic signed [63:0] TMIN = -TMAX - 64'sd1;
   localparam int NUM_W  = 63;
   localparam int DIFF_W = 47;
   localparam int IDX_W  = 17;
   localparam int W      = cfrh_pkg::CRD_W;

   typedef struct packed {
      logic [W-1:0] sx;
      logic [W-1:0] sy;
      logic         tneg;
      logic         xneg;
      logic         yneg;
      logic         dzero;
   } ray_side_type;

   typedef struct packed {
      logic                         hit;
      logic [W-1:0]                 distance;
      logic [cfrh_pkg::COLOR_W-1:0] color;
   } res_type;

   cfrh_pkg::cfg_type cfg;

   cfrh_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .cfg        (cfg)
   );

   logic en;
   logic skid_v_ff, out_v_ff;
   res_type skid_ff, out_ff;

   // Whole pipeline moves while the skid stage is free
   assign en         = ~skid_v_ff;
   assign req_tready = en;

   // ---------------- floor geometry from registers ----------------
   logic [cfrh_pkg::LEN_W-1:0]  len_eff;
   logic signed [63:0]          org64;
   logic [cfrh_pkg::SPAN_W-1:0] span_ff, span_in;
   logic signed [63:0]          lim_ff, lim_in;
   logic [W-1:0]                org_s;

   assign len_eff = (cfg.tile_length == '0) ? {{(cfrh_pkg::LEN_W-1){1'b0}}, 1'b1}
                                            : cfg.tile_length;
   assign org_s   = cfrh_pkg::sext_crd(cfg.floor_origin, CW);
   assign org64   = {{(64-W){org_s[W-1]}}, org_s};
   assign span_in = cfg.tile_count * len_eff;
   assign lim_in  = org64 + {{(64-cfrh_pkg::SPAN_W){1'b0}}, span_ff};

   always_ff @(posedge clock) begin
      span_ff <= span_in;
      lim_ff  <= lim_in;
   end

   // ---------------- stage A: unpack, sign-extend, magnitudes ----------------
   logic [W-1:0] sx, sy, sz, dx, dy, dz;
   logic         nneg;
   logic         a_v_ff;
   logic [W-1:0] a_szm_ff, a_dxm_ff, a_dym_ff, a_dzm_ff;
   ray_side_type a_side_ff, a_side_in;

   assign sx   = cfrh_pkg::sext_crd(req_tdata[31:0], CW);
   assign sy   = cfrh_pkg::sext_crd(req_tdata[63:32], CW);
   assign sz   = cfrh_pkg::sext_crd(req_tdata[95:64], CW);
   assign dx   = cfrh_pkg::sext_crd(req_tdata[127:96], CW);
   assign dy   = cfrh_pkg::sext_crd(req_tdata[159:128], CW);
   assign dz   = cfrh_pkg::sext_crd(req_tdata[191:160], CW);
   // numerator -start_z is negative when start_z is positive
   assign nneg = ~sz[W-1] && (sz != '0);

   always_comb begin
      a_side_in.sx    = sx;
      a_side_in.sy    = sy;
      a_side_in.tneg  = nneg ^ dz[W-1];
      a_side_in.xneg  = nneg ^ dx[W-1] ^ dz[W-1];
      a_side_in.yneg  = nneg ^ dy[W-1] ^ dz[W-1];
      a_side_in.dzero = (dz == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_szm_ff  <= cfrh_pkg::mag_crd(sz);
         a_dxm_ff  <= cfrh_pkg::mag_crd(dx);
         a_dym_ff  <= cfrh_pkg::mag_crd(dy);
         a_dzm_ff  <= cfrh_pkg::mag_crd(dz);
         a_side_ff <= a_side_in;
      end
   end

   // ---------------- stage B: numerator products ----------------
   logic                        b_v_ff;
   logic [2:0][NUM_W-1:0]       b_num_ff, b_num_in;
   logic [W-1:0]                b_dzm_ff;
   ray_side_type                b_side_ff;
   logic [63:0]                 prod_x, prod_y;

   assign prod_x      = a_szm_ff * a_dxm_ff;
   assign prod_y      = a_szm_ff * a_dym_ff;
   assign b_num_in[0] = {{(NUM_W-W-16){1'b0}}, a_szm_ff, 16'h0000};
   assign b_num_in[1] = prod_x[NUM_W-1:0];
   assign b_num_in[2] = prod_y[NUM_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         b_v_ff <= 1'b0;
      end else if (en) begin
         b_v_ff <= a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         b_num_ff  <= b_num_in;
         b_dzm_ff  <= a_dzm_ff;
         b_side_ff <= a_side_ff;
      end
   end

   // ---------------- divide t, x offset, y offset by |dir_z| ----------------
   logic                    d1_v;
   logic [2:0][NUM_W-1:0]   d1_q;
   logic [2:0][W-1:0]       d1_r;
   ray_side_type            d1_side;

   cfrh_div #(
      .DW(W), .QW(NUM_W), .LN(3), .SW($bits(ray_side_type))
   ) u_div_ray (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (b_v_ff),
      .den      (b_dzm_ff),
      .num_hi   ('0),
      .num_lo   (b_num_ff),
      .side_in  (b_side_ff),
      .out_valid(d1_v),
      .quot     (d1_q),
      .rem      (d1_r),
      .side_out (d1_side)
   );

   // ---------------- stage C: apply signs ----------------
   logic               c_v_ff;
   logic signed [63:0] c_t_ff, c_fx_ff, c_fy_ff;
   logic signed [63:0] c_t_in, c_fx_in, c_fy_in;
   ray_side_type       c_side_ff;

   always_comb begin
      c_t_in  = d1_side.tneg ? -{1'b0, d1_q[0]} : {1'b0, d1_q[0]};
      // floor: a negative inexact quotient steps down by one
      c_fx_in = {1'b0, d1_q[1]};
      if (d1_side.xneg) begin
         c_fx_in = (d1_r[1] != '0) ? ~{1'b0, d1_q[1]} : -{1'b0, d1_q[1]};
      end
      c_fy_in = {1'b0, d1_q[2]};
      if (d1_side.yneg) begin
         c_fy_in = (d1_r[2] != '0) ? ~{1'b0, d1_q[2]} : -{1'b0, d1_q[2]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_v_ff <= 1'b0;
      end else if (en) begin
         c_v_ff <= d1_v;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c_t_ff    <= c_t_in;
         c_fx_ff   <= c_fx_in;
         c_fy_ff   <= c_fy_in;
         c_side_ff <= d1_side;
      end
   end

   // ---------------- stage D: hit point, saturate t ----------------
   logic               d_v_ff, d_dzero_ff;
   logic signed [63:0] d_px_ff, d_py_ff;
   logic [W-1:0]       d_t_ff;
   logic signed [63:0] d_t_sat;

   assign d_t_sat = (c_t_ff > TMAX) ? TMAX : ((c_t_ff < TMIN) ? TMIN : c_t_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
      end else if (en) begin
         d_v_ff <= c_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_px_ff    <= {{(64-W){c_side_ff.sx[W-1]}}, c_side_ff.sx} + c_fx_ff;
         d_py_ff    <= {{(64-W){c_side_ff.sy[W-1]}}, c_side_ff.sy} + c_fy_ff;
         d_t_ff     <= d_t_sat[W-1:0];
         d_dzero_ff <= c_side_ff.dzero;
      end
   end

   // ---------------- stage E: area test, offsets from corner ----------------
   logic                      e_v_ff, e_hit_ff, e_hit_in;
   logic [W-1:0]              e_t_ff;
   logic [1:0][DIFF_W-1:0]    e_off_ff;
   logic signed [63:0]        off_x, off_y;

   assign off_x    = d_px_ff - org64;
   assign off_y    = d_py_ff - org64;
   assign e_hit_in = ~d_dzero_ff && (d_px_ff >= org64) && (d_px_ff <= lim_ff)
                     && (d_py_ff >= org64) && (d_py_ff <= lim_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         e_v_ff <= 1'b0;
      end else if (en) begin
         e_v_ff <= d_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e_hit_ff    <= e_hit_in;
         e_t_ff      <= d_t_ff;
         e_off_ff[0] <= off_x[DIFF_W-1:0];
         e_off_ff[1] <= off_y[DIFF_W-1:0];
      end
   end

   // ---------------- divide offsets by tile length ----------------
   logic [1:0][cfrh_pkg::LEN_W-1:0] t_hi;
   logic [1:0][IDX_W-1:0]           t_lo, d2_q;
   logic                            d2_v;
   logic [W:0]                      d2_side;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         t_hi[l] = {{(cfrh_pkg::LEN_W-(DIFF_W-IDX_W)){1'b0}}, e_off_ff[l][DIFF_W-1:IDX_W]};
         t_lo[l] = e_off_ff[l][IDX_W-1:0];
      end
   end

   cfrh_div #(
      .DW(cfrh_pkg::LEN_W), .QW(IDX_W), .LN(2), .SW(W + 1)
   ) u_div_tile (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (e_v_ff),
      .den      (len_eff),
      .num_hi   (t_hi),
      .num_lo   (t_lo),
      .side_in  ({e_hit_ff, e_t_ff}),
      .out_valid(d2_v),
      .quot     (d2_q),
      .rem      (),
      .side_out (d2_side)
   );

   // ---------------- pick colour by index parity ----------------
   res_type p_res;

   always_comb begin
      p_res.hit      = d2_side[W];
      p_res.distance = d2_side[W] ? d2_side[W-1:0] : cfrh_pkg::MISS_DISTANCE;
      p_res.color    = '0;
      if (d2_side[W]) begin
         p_res.color = (d2_q[0][0] ^ d2_q[1][0]) ? cfg.odd_color : cfg.main_color;
      end
   end

   // ---------------- output register with skid stage ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (!out_v_ff || rsp_tready) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff  <= d2_v;
         end
      end else if (en && d2_v) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_v_ff || rsp_tready) begin
         out_ff <= skid_v_ff ? skid_ff : p_res;
      end else if (en && d2_v) begin
         skid_ff <= p_res;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {out_ff.color, out_ff.distance};
   assign rsp_tuser  = out_ff.hit;

   // ---------------- checks ----------------
   `CFRH_ASSERT(a_skid_needs_out, clock, reset, skid_v_ff |-> out_v_ff)
   `CFRH_ASSERT_NEXT(a_out_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `CFRH_ASSERT(a_hit_color, clock, reset, rsp_tvalid && rsp_tuser |-> (rsp_tdata[55:32] == cfg.main_color || rsp_tdata[55:32] == cfg.odd_color))
   `CFRH_ASSERT(a_miss_fields, clock, reset, rsp_tvalid && !rsp_tuser |-> (rsp_tdata == {24'h000000, cfrh_pkg::MISS_DISTANCE}))

endmodule

@@ rtl/core/cfrh_csr.sv @@
// ----------------------------------------------------------------------------
// Checkerboard floor ray hit: register file
// APB-style write/read of the colour and floor geometry registers.
// ----------------------------------------------------------------------------
module cfrh_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cfrh_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [cfrh_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [cfrh_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output cfrh_pkg::cfg_type                   cfg
);

   cfrh_pkg::cfg_type cfg_ff;
   logic [cfrh_pkg::REG_IDX_W-1:0] idx;
   logic wr;

   assign idx        = csr_paddr[cfrh_pkg::CSR_ADDR_W-1:2];
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   // Write registers on the access beat
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.main_color   <= cfrh_pkg::MAIN_COLOR_RST;
         cfg_ff.odd_color    <= cfrh_pkg::ODD_COLOR_RST;
         cfg_ff.floor_origin <= cfrh_pkg::FLOOR_ORIGIN_RST;
         cfg_ff.tile_length  <= cfrh_pkg::TILE_LENGTH_RST;
         cfg_ff.tile_count   <= cfrh_pkg::TILE_COUNT_RST;
      end else if (wr) begin
         case (idx)
            cfrh_pkg::REG_MAIN_COLOR: begin
               cfg_ff.main_color <= csr_pwdata[cfrh_pkg::COLOR_W-1:0];
            end
            cfrh_pkg::REG_ODD_COLOR: begin
               cfg_ff.odd_color <= csr_pwdata[cfrh_pkg::COLOR_W-1:0];
            end
            cfrh_pkg::REG_FLOOR_ORIGIN: begin
               cfg_ff.floor_origin <= csr_pwdata[cfrh_pkg::CRD_W-1:0];
            end
            cfrh_pkg::REG_TILE_LENGTH: begin
               cfg_ff.tile_length <= csr_pwdata[cfrh_pkg::LEN_W-1:0];
            end
            cfrh_pkg::REG_TILE_COUNT: begin
               cfg_ff.tile_count <= csr_pwdata[cfrh_pkg::CNT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Read mux
   always_comb begin
      csr_prdata = '0;
      case (idx)
         cfrh_pkg::REG_MAIN_COLOR:   csr_prdata = {8'h00, cfg_ff.main_color};
         cfrh_pkg::REG_ODD_COLOR:    csr_prdata = {8'h00, cfg_ff.odd_color};
         cfrh_pkg::REG_FLOOR_ORIGIN: csr_prdata = cfg_ff.floor_origin;
         cfrh_pkg::REG_TILE_LENGTH:  csr_prdata = {1'b0, cfg_ff.tile_length};
         cfrh_pkg::REG_TILE_COUNT:   csr_prdata = {16'h0000, cfg_ff.tile_count};
         default:                    csr_prdata = '0;
      endcase
   end

endmodule

@@ rtl/core/cfrh_div.sv @@
// ----------------------------------------------------------------------------
// Checkerboard floor ray hit: pipelined divider
// Restoring division, one quotient bit per stage, LN lanes sharing a divisor.
// The caller guarantees num_hi < den; quotient is the low QW bits.
// ----------------------------------------------------------------------------
module cfrh_div #(
   parameter int DW = 32,
   parameter int QW = 63,
   parameter int LN = 1,
   parameter int SW = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [DW-1:0]             den,
   input  logic [LN-1:0][DW-1:0]     num_hi,
   input  logic [LN-1:0][QW-1:0]     num_lo,
   input  logic [SW-1:0]             side_in,
   output logic                      out_valid,
   output logic [LN-1:0][QW-1:0]     quot,
   output logic [LN-1:0][DW-1:0]     rem,
   output logic [SW-1:0]             side_out
);

   logic [QW-1:0]                   valid_ff;
   logic [QW-1:0][DW-1:0]           den_ff,  den_in;
   logic [QW-1:0][SW-1:0]           side_ff, side_in_sh;
   logic [QW-1:0][LN-1:0][DW-1:0]   rem_ff,  rem_in,  src_rem;
   logic [QW-1:0][LN-1:0][QW-1:0]   nq_ff,   nq_in,   src_nq;

   assign den_in     = {den_ff[QW-2:0], den};
   assign side_in_sh = {side_ff[QW-2:0], side_in};

   // One restoring step per stage and lane
   always_comb begin
      logic [DW:0] trial;
      logic [DW:0] diff;
      trial = '0;
      diff  = '0;
      src_rem[0] = num_hi;
      src_nq[0]  = num_lo;
      for (int k = 1; k < QW; k++) begin
         src_rem[k] = rem_ff[k-1];
         src_nq[k]  = nq_ff[k-1];
      end
      for (int k = 0; k < QW; k++) begin
         for (int l = 0; l < LN; l++) begin
            trial = {src_rem[k][l], src_nq[k][l][QW-1]};
            diff  = trial - {1'b0, den_in[k]};
            rem_in[k][l] = diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
            nq_in[k][l]  = {src_nq[k][l][QW-2:0], ~diff[DW]};
         end
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[QW-2:0], in_valid};
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (en) begin
         den_ff  <= den_in;
         side_ff <= side_in_sh;
         rem_ff  <= rem_in;
         nq_ff   <= nq_in;
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign quot      = nq_ff[QW-1];
   assign rem       = rem_ff[QW-1];
   assign side_out  = side_ff[QW-1];

endmodule
